/* rtl/cartesian_to_sphere_geodetic_defines.svh */
// Assertion macros for the Cartesian to spherical converter.
// Used by the top level only; expects signals clk and rst in scope.
`ifndef CARTESIAN_TO_SPHERE_GEODETIC_DEFINES_SVH
`define CARTESIAN_TO_SPHERE_GEODETIC_DEFINES_SVH

`define C2SG_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("c2sg: same-cycle check failed");

`define C2SG_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("c2sg: next-cycle check failed");

`endif

/* rtl/c2sg_pkg.sv */
// Shared types, constants and the arctangent table function of the converter.
// No dependencies; used by the root, CORDIC and top-level modules.
package c2sg_pkg;

  localparam int RootBits     = 50;
  localparam int SqrtInBits   = 100;
  localparam int SqrtLat      = 51;
  localparam int CordicStages = 31;
  localparam int CordicLat    = 35;
  localparam int AngleBits    = 36;

  localparam logic signed [AngleBits-1:0] Units45  = 36'sd754974720;
  localparam logic signed [AngleBits-1:0] Units90  = 36'sd1509949440;
  localparam logic signed [AngleBits-1:0] Units180 = 36'sd3019898880;

  localparam logic [63:0] PiNum = 64'd245850922;
  localparam logic [63:0] PiDen = 64'd78256779;
  localparam logic [63:0] KNum  = 64'd180 * PiDen;
  localparam logic [63:0] KQuot = KNum / PiNum;
  localparam logic [63:0] KRem  = KNum % PiNum;

  typedef struct packed {
    logic signed [39:0] px;
    logic signed [39:0] py;
    logic signed [39:0] pz;
    logic               last;
  } point_t;

  function automatic logic [63:0] k_const();
    logic [63:0] k;
    logic [63:0] rem;
    int j;
    k = KQuot;
    rem = KRem;
    for (j = 0; j < 54; j++) begin
      rem = rem << 1;
      k = k << 1;
      if (rem >= PiNum) begin
        rem = rem - PiNum;
        k[0] = 1'b1;
      end
    end
    return k;
  endfunction

  function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [63:0] r;
    int j;
    q = '0;
    r = '0;
    for (j = 63; j >= 0; j--) begin
      r = {r[62:0], a[j]};
      if (r >= b) begin
        r = r - b;
        q[j] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic signed [AngleBits-1:0] atan_units(input int i);
    logic [63:0] k;
    logic [63:0] sum;
    logic [63:0] v;
    logic [63:0] dv;
    int term;
    int sh;
    k = k_const();
    sum = '0;
    if (i == 0) begin
      return Units45;
    end
    for (term = 0; term < 64; term++) begin
      sh = i * (2 * term + 1);
      if (sh < 64) begin
        dv = 64'(2 * term + 1);
        v = udiv(k >> sh, dv);
        if (term[0]) begin
          sum = sum - v;
        end else begin
          sum = sum + v;
        end
      end
    end
    sum = (sum + (64'd1 << 29)) >> 30;
    return $signed(sum[AngleBits-1:0]);
  endfunction

endpackage

/* rtl/c2sg_sqrt.sv */
// Pipelined rounded integer square root, one root bit per register stage.
// Depends on c2sg_pkg for its widths.
module c2sg_sqrt (
  input  logic                               clk,
  input  logic                               en,
  input  logic [c2sg_pkg::SqrtInBits-1:0]    radicand,
  output logic [c2sg_pkg::RootBits:0]        root
);

  localparam int R = c2sg_pkg::RootBits;
  localparam int N = c2sg_pkg::SqrtInBits;

  logic [N-1:0] rad_q  [1:R];
  logic [R+1:0] rem_q  [1:R];
  logic [R-1:0] root_q [1:R];

  for (genvar j = 0; j < R; j++) begin : g_step
    logic [N-1:0] rad_i;
    logic [R+1:0] rem_i;
    logic [R-1:0] root_i;
    logic [R+3:0] trial;
    logic [R+3:0] t;
    logic [R+3:0] diff;

    if (j == 0) begin : g_first
      assign rad_i  = radicand;
      assign rem_i  = '0;
      assign root_i = '0;
    end else begin : g_next
      assign rad_i  = rad_q[j];
      assign rem_i  = rem_q[j];
      assign root_i = root_q[j];
    end

    always_comb begin
      trial = {rem_i, rad_i[N-1:N-2]};
      t     = {2'b00, root_i, 2'b01};
      diff  = trial - t;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[j+1] <= rad_i << 2;
        if (trial >= t) begin
          rem_q[j+1]  <= diff[R+1:0];
          root_q[j+1] <= {root_i[R-2:0], 1'b1};
        end else begin
          rem_q[j+1]  <= trial[R+1:0];
          root_q[j+1] <= {root_i[R-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root <= {1'b0, root_q[R]} + {{R{1'b0}}, (rem_q[R] > {2'b00, root_q[R]})};
    end
  end

endmodule

/* rtl/c2sg_cordic.sv */
// Pipelined vectoring CORDIC giving atan2 in units of 2^-24 degree.
// Depends on c2sg_pkg for the angle table and constants.
module c2sg_cordic (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [63:0]                    sin_val,
  input  logic signed [63:0]                    cos_val,
  output logic signed [c2sg_pkg::AngleBits-1:0] angle
);

  localparam int NS = c2sg_pkg::CordicStages;
  localparam int AW = c2sg_pkg::AngleBits;

  logic signed [63:0]   s0, c0, s1, c1;
  logic [63:0]          m0, m1;
  logic signed [AW-1:0] base0, base1;
  logic                 zero0, zero1;

  logic signed [63:0]   s_a, c_a, ms;
  logic signed [AW-1:0] base_a;
  logic signed [63:0]   s_n1, c_n1, s_n2, c_n2;
  logic [63:0]          m_n1, m_n2;

  logic signed [63:0]   xs  [0:NS];
  logic signed [63:0]   xc  [0:NS];
  logic signed [AW-1:0] ang [0:NS];
  logic                 zr  [0:NS];

  always_comb begin
    if (cos_val[63]) begin
      s_a    = -sin_val;
      c_a    = -cos_val;
      base_a = sin_val[63] ? -c2sg_pkg::Units180 : c2sg_pkg::Units180;
    end else begin
      s_a    = sin_val;
      c_a    = cos_val;
      base_a = '0;
    end
    ms = s_a[63] ? -s_a : s_a;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0    <= s_a;
      c0    <= c_a;
      m0    <= ($unsigned(ms) > $unsigned(c_a)) ? $unsigned(ms) : $unsigned(c_a);
      base0 <= base_a;
      zero0 <= (sin_val == '0) && (cos_val == '0);
    end
  end

  always_comb begin
    s_n1 = s0;
    c_n1 = c0;
    m_n1 = m0;
    if (m_n1[63:27] == '0) begin
      s_n1 = s_n1 <<< 32;
      c_n1 = c_n1 <<< 32;
      m_n1 = m_n1 << 32;
    end
    if (m_n1[63:43] == '0) begin
      s_n1 = s_n1 <<< 16;
      c_n1 = c_n1 <<< 16;
      m_n1 = m_n1 << 16;
    end
    if (m_n1[63:51] == '0) begin
      s_n1 = s_n1 <<< 8;
      c_n1 = c_n1 <<< 8;
      m_n1 = m_n1 << 8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1    <= s_n1;
      c1    <= c_n1;
      m1    <= m_n1;
      base1 <= base0;
      zero1 <= zero0;
    end
  end

  always_comb begin
    s_n2 = s1;
    c_n2 = c1;
    m_n2 = m1;
    if (m_n2[63:55] == '0) begin
      s_n2 = s_n2 <<< 4;
      c_n2 = c_n2 <<< 4;
      m_n2 = m_n2 << 4;
    end
    if (m_n2[63:57] == '0) begin
      s_n2 = s_n2 <<< 2;
      c_n2 = c_n2 <<< 2;
      m_n2 = m_n2 << 2;
    end
    if (m_n2[63:58] == '0) begin
      s_n2 = s_n2 <<< 1;
      c_n2 = c_n2 <<< 1;
      m_n2 = m_n2 << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0]  <= s_n2;
      xc[0]  <= c_n2;
      ang[0] <= base1;
      zr[0]  <= zero1;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_iter
    localparam logic signed [AW-1:0] Step = c2sg_pkg::atan_units(i);
    always_ff @(posedge clk) begin
      if (en) begin
        zr[i+1] <= zr[i];
        if (!xs[i][63]) begin
          xc[i+1]  <= xc[i] + (xs[i] >>> i);
          xs[i+1]  <= xs[i] - (xc[i] >>> i);
          ang[i+1] <= ang[i] + Step;
        end else begin
          xc[i+1]  <= xc[i] - (xs[i] >>> i);
          xs[i+1]  <= xs[i] + (xc[i] >>> i);
          ang[i+1] <= ang[i] - Step;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= zr[NS] ? '0 : ang[NS];
    end
  end

endmodule

/* rtl/cartesian_to_sphere_geodetic.sv */
// Top level of the Cartesian to spherical converter.
// Depends on c2sg_pkg, c2sg_sqrt, c2sg_cordic and the assertion macro header.
//
// The block accepts one point in every cycle unless a result is held by
// out_stall; each result passes through the 50-stage square root and the
// 31-stage CORDIC pipelines. While a finished result is held by out_stall
// the whole pipeline stops and in_stall is raised.
`include "cartesian_to_sphere_geodetic_defines.svh"

module cartesian_to_sphere_geodetic (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [39:0] pos_x,
  input  logic signed [39:0] pos_y,
  input  logic signed [39:0] pos_z,
  input  logic               last_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] latitude,
  output logic signed [32:0] longitude,
  output logic signed [40:0] altitude,
  output logic               last_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [38:0]        cfg_data
);

  localparam int SL    = c2sg_pkg::SqrtLat;
  localparam int CL    = c2sg_pkg::CordicLat;
  localparam int Total = 5 + SL + CL;
  localparam int AW    = c2sg_pkg::AngleBits;

  logic              en;
  logic [Total-1:0]  vld;
  logic [38:0]       sphere_radius;

  c2sg_pkg::point_t  p1, p2, p3, p4, p5;
  logic [39:0]       mag_x, mag_y, mag_z;
  logic [39:0]       hh_x, hl_x, ll_x, hh_y, hl_y, ll_y, hh_z, hl_z, ll_z;
  logic [79:0]       sq_x, sq_y, sq_z, sqy4, hsum, rsum;
  logic [99:0]       hscaled;

  logic [c2sg_pkg::RootBits:0] r_root, h_root;
  c2sg_pkg::point_t  pd [1:SL];
  logic [40:0]       rd_r [1:CL];
  logic              rd_last [1:CL];

  logic signed [63:0]   lat_s, lat_c, lon_s, lon_c;
  logic signed [AW-1:0] lat_ang, lon_ang, lat_cl, lon_cl;
  logic signed [41:0]   alt_full;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius <= 39'd1633098547;
    end else if (cfg_valid) begin
      sphere_radius <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[Total-2:0], in_valid};
      out_valid <= vld[Total-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1    <= '{px: pos_x, py: pos_y, pz: pos_z, last: last_in};
      mag_x <= pos_x[39] ? $unsigned(-pos_x) : $unsigned(pos_x);
      mag_y <= pos_y[39] ? $unsigned(-pos_y) : $unsigned(pos_y);
      mag_z <= pos_z[39] ? $unsigned(-pos_z) : $unsigned(pos_z);

      p2   <= p1;
      hh_x <= {20'b0, mag_x[39:20]} * {20'b0, mag_x[39:20]};
      hl_x <= {20'b0, mag_x[39:20]} * {20'b0, mag_x[19:0]};
      ll_x <= {20'b0, mag_x[19:0]}  * {20'b0, mag_x[19:0]};
      hh_y <= {20'b0, mag_y[39:20]} * {20'b0, mag_y[39:20]};
      hl_y <= {20'b0, mag_y[39:20]} * {20'b0, mag_y[19:0]};
      ll_y <= {20'b0, mag_y[19:0]}  * {20'b0, mag_y[19:0]};
      hh_z <= {20'b0, mag_z[39:20]} * {20'b0, mag_z[39:20]};
      hl_z <= {20'b0, mag_z[39:20]} * {20'b0, mag_z[19:0]};
      ll_z <= {20'b0, mag_z[19:0]}  * {20'b0, mag_z[19:0]};

      p3   <= p2;
      sq_x <= {hh_x, 40'b0} + {19'b0, hl_x, 21'b0} + {40'b0, ll_x};
      sq_y <= {hh_y, 40'b0} + {19'b0, hl_y, 21'b0} + {40'b0, ll_y};
      sq_z <= {hh_z, 40'b0} + {19'b0, hl_z, 21'b0} + {40'b0, ll_z};

      p4   <= p3;
      hsum <= sq_x + sq_z;
      sqy4 <= sq_y;

      p5      <= p4;
      rsum    <= hsum + sqy4;
      hscaled <= {hsum, 20'b0};
    end
  end

  c2sg_sqrt u_sqrt_r (
    .clk      (clk),
    .en       (en),
    .radicand ({20'b0, rsum}),
    .root     (r_root)
  );

  c2sg_sqrt u_sqrt_h (
    .clk      (clk),
    .en       (en),
    .radicand (hscaled),
    .root     (h_root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      pd[1] <= p5;
      for (int j = 2; j <= SL; j++) begin
        pd[j] <= pd[j-1];
      end
      rd_r[1]    <= r_root[40:0];
      rd_last[1] <= pd[SL].last;
      for (int j = 2; j <= CL; j++) begin
        rd_r[j]    <= rd_r[j-1];
        rd_last[j] <= rd_last[j-1];
      end
    end
  end

  assign lat_s = {{14{pd[SL].py[39]}}, pd[SL].py, 10'b0};
  assign lat_c = {13'b0, h_root};
  assign lon_s = {{24{pd[SL].px[39]}}, pd[SL].px};
  assign lon_c = {{24{pd[SL].pz[39]}}, pd[SL].pz};

  c2sg_cordic u_cordic_lat (
    .clk     (clk),
    .en      (en),
    .sin_val (lat_s),
    .cos_val (lat_c),
    .angle   (lat_ang)
  );

  c2sg_cordic u_cordic_lon (
    .clk     (clk),
    .en      (en),
    .sin_val (lon_s),
    .cos_val (lon_c),
    .angle   (lon_ang)
  );

  always_comb begin
    if (lat_ang > c2sg_pkg::Units90) begin
      lat_cl = c2sg_pkg::Units90;
    end else if (lat_ang < -c2sg_pkg::Units90) begin
      lat_cl = -c2sg_pkg::Units90;
    end else begin
      lat_cl = lat_ang;
    end
    if (lon_ang > c2sg_pkg::Units180) begin
      lon_cl = c2sg_pkg::Units180;
    end else if (lon_ang < -c2sg_pkg::Units180) begin
      lon_cl = -c2sg_pkg::Units180;
    end else begin
      lon_cl = lon_ang;
    end
    alt_full = $signed({1'b0, rd_r[CL]}) - $signed({3'b0, sphere_radius});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      latitude  <= lat_cl[31:0];
      longitude <= lon_cl[32:0];
      altitude  <= alt_full[40:0];
      last_out  <= rd_last[CL];
    end
  end

  `C2SG_ASSERT_IMPL(a_stall_only_when_held, in_stall, out_valid && out_stall)
  `C2SG_ASSERT_NEXT(a_valid_reaches_output, vld[Total-1] && en, out_valid)
  `C2SG_ASSERT_IMPL(a_lat_range, out_valid, (latitude <= 32'sd1509949440) && (latitude >= -32'sd1509949440))
  `C2SG_ASSERT_IMPL(a_lon_range, out_valid, (longitude <= 33'sd3019898880) && (longitude >= -33'sd3019898880))

endmodule
